[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the linearizer modules
// Implication checks in the same cycle and in the following cycle.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/ntl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntl_pkg
// Types and constants of the NTC thermistor linearizer.
// ----------------------------------------------------------------------------
package ntl_pkg;

	localparam int LN_FRAC = 24;          // fraction bits of the log values
	localparam int Q_BITS  = 41;          // quotient bits, kelvin in centidegrees
	localparam int QDEPTH  = 4;           // front/back queue depth
	localparam int QAW     = 2;           // queue pointer width

	localparam logic [31:0] LN2_Q32      = 32'hB17217F8;
	localparam logic [15:0] KELVIN_CENTI = 16'd27315;

	typedef enum logic [2:0] {
		REG_COEF_A       = 3'd0,
		REG_COEF_B       = 3'd1,
		REG_COEF_C       = 3'd2,
		REG_REF_MV       = 3'd3,
		REG_FIXED_OHMS   = 3'd4,
		REG_ON_TOP       = 3'd5,
		REG_TEMP_FLOOR   = 3'd6,
		REG_TEMP_CEILING = 3'd7
	} ntl_reg_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_LIMIT = 2'd2
	} ntl_status_t;

	// settings seen by the front part
	typedef struct packed {
		logic [11:0] ref_mv;
		logic [19:0] fixed_ohms;
		logic        on_top;
	} ntl_fcfg_t;

	// settings seen by the back part
	typedef struct packed {
		logic signed [47:0] coef_a;
		logic signed [47:0] coef_b;
		logic signed [47:0] coef_c;
		logic signed [15:0] temp_floor;
		logic signed [15:0] temp_ceiling;
	} ntl_bcfg_t;

	// classified sample: divider ratio as num/den
	typedef struct packed {
		logic        bad;
		logic [31:0] num;
		logic [11:0] den;
	} ntl_item_t;

endpackage

[hdl/ntl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntl_in_if / ntl_out_if
// Valid/ready channels for tap samples and temperature results.
// ----------------------------------------------------------------------------
interface ntl_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] tap_millivolts;

	modport source (output valid, output tap_millivolts, input ready);
	modport sink   (input valid, input tap_millivolts, output ready);
endinterface

interface ntl_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_centi_c;
	logic [1:0]         status;

	modport source (output valid, output temp_centi_c, output status, input ready);
	modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

[hdl/ntc_thermistor_linearizer_top.sv]
`timescale 1ns / 1ps
// Each accepted sample passes through the queue and the back pipeline to the result register.
// Throughput: one sample per cycle; the back pipeline (24 log squaring stages,
// 41 restoring division stages) advances as a whole when the result register frees.
// A four-beat queue lets the front keep accepting while the back is stalled.
// Reset (arst_n low, asynchronous) clears all valid state and restores the
// register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
// ntc_thermistor_linearizer_top
// NTC divider voltage to temperature via Steinhart-Hart, register file and glue.
// ----------------------------------------------------------------------------
module ntc_thermistor_linearizer_top #(
	parameter int COEF_FRAC_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	ntl_in_if.sink      sample,
	ntl_out_if.source   result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [47:0] cfg_data
);

	ntl_pkg::ntl_fcfg_t fcfg_q;
	ntl_pkg::ntl_bcfg_t bcfg_q;
	ntl_pkg::ntl_item_t push_item, head;
	logic               push, pop, q_full, q_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcfg_q.coef_a       <= '0;
			bcfg_q.coef_b       <= '0;
			bcfg_q.coef_c       <= '0;
			fcfg_q.ref_mv       <= 12'd3000;
			fcfg_q.fixed_ohms   <= 20'd10000;
			fcfg_q.on_top       <= 1'b1;
			bcfg_q.temp_floor   <= -16'sd4000;
			bcfg_q.temp_ceiling <= 16'sd12500;
		end else if (cfg_we) begin
			case (cfg_idx)
				ntl_pkg::REG_COEF_A:       bcfg_q.coef_a       <= cfg_data;
				ntl_pkg::REG_COEF_B:       bcfg_q.coef_b       <= cfg_data;
				ntl_pkg::REG_COEF_C:       bcfg_q.coef_c       <= cfg_data;
				ntl_pkg::REG_REF_MV:       fcfg_q.ref_mv       <= cfg_data[11:0];
				ntl_pkg::REG_FIXED_OHMS:   fcfg_q.fixed_ohms   <= cfg_data[19:0];
				ntl_pkg::REG_ON_TOP:       fcfg_q.on_top       <= cfg_data[0];
				ntl_pkg::REG_TEMP_FLOOR:   bcfg_q.temp_floor   <= cfg_data[15:0];
				ntl_pkg::REG_TEMP_CEILING: bcfg_q.temp_ceiling <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ntl_front u_front (
		.sample (sample),
		.cfg    (fcfg_q),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	ntl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.avail     (q_avail),
		.head      (head)
	);

	ntl_back #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (bcfg_q),
		.item_vld   (q_avail),
		.item       (head),
		.item_pop   (pop),
		.res_vld    (result.valid),
		.res_rdy    (result.ready),
		.res_temp   (result.temp_centi_c),
		.res_status (result.status)
	);

endmodule

[hdl/ntl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntl_front
// Accepts tap beats, flags out-of-range voltages and forms the divider ratio.
// ----------------------------------------------------------------------------
module ntl_front (
	ntl_in_if.sink              sample,
	input  ntl_pkg::ntl_fcfg_t  cfg,
	input  logic                q_full,
	output logic                push,
	output ntl_pkg::ntl_item_t  item
);

	logic [11:0] v;
	logic [11:0] diff;
	logic [11:0] mul_op;

	assign v            = sample.tap_millivolts;
	assign diff         = cfg.ref_mv - v;
	assign sample.ready = !q_full;
	assign push         = sample.valid && !q_full;

	// thermistor on top: R = fixed*(ref-v)/v, else fixed*v/(ref-v)
	assign mul_op   = cfg.on_top ? diff : v;
	assign item.bad = (v == '0) || (v >= cfg.ref_mv) || (cfg.fixed_ohms == '0);
	assign item.num = cfg.fixed_ohms * mul_op;
	assign item.den = cfg.on_top ? v : diff;

endmodule

[hdl/ntl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntl_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ntl_pkg::ntl_item_t push_item,
	input  logic               pop,
	output logic               full,
	output logic               avail,
	output ntl_pkg::ntl_item_t head
);

	ntl_pkg::ntl_item_t         mem_q [ntl_pkg::QDEPTH];
	logic [ntl_pkg::QAW-1:0]    wr_q;
	logic [ntl_pkg::QAW-1:0]    rd_q;
	logic [ntl_pkg::QAW:0]      cnt_q;

	assign full  = (cnt_q == (ntl_pkg::QAW+1)'(ntl_pkg::QDEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`ASSERT_IMPL(a_pop_avail, clk, arst_n, pop, cnt_q != '0)

endmodule

[hdl/ntl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntl_back
// Log, Steinhart-Hart polynomial, reciprocal and limit check, fully pipelined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntl_back #(
	parameter int COEF_FRAC_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ntl_pkg::ntl_bcfg_t cfg,
	input  logic               item_vld,
	input  ntl_pkg::ntl_item_t item,
	output logic               item_pop,
	output logic               res_vld,
	input  logic               res_rdy,
	output logic signed [15:0] res_temp,
	output logic [1:0]         res_status
);

	localparam int LNF = ntl_pkg::LN_FRAC;
	localparam int QB  = ntl_pkg::Q_BITS;
	localparam logic [63:0] KEL_NUM = 64'd100 << COEF_FRAC_BITS;

	function automatic logic [36:0] norm32(input logic [31:0] x);
		logic [4:0] e;
		e = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) e = 5'(i);
		end
		return {e, x << (5'd31 - e)};
	endfunction

	// one squaring of the Q31 mantissa: {log bit, new mantissa}
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] p;
		p = m * m;
		return p[63] ? {1'b1, p[63:32]} : {1'b0, p[62:31]};
	endfunction

	logic adv;

	// whole back part moves together; output register is the last stage
	assign adv      = !res_vld || res_rdy;
	assign item_pop = adv && item_vld;

	// ---- s1: normalise
	logic        v_s1, bad_s1;
	logic [4:0]  xn_s1, xd_s1;
	logic [31:0] mn_s1, md_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= item_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1         <= item.bad;
			{xn_s1, mn_s1} <= norm32(item.num);
			{xd_s1, md_s1} <= norm32({20'd0, item.den});
		end
	end

	// ---- squaring chain, one log2 fraction bit per stage
	logic        sq_v_sk   [LNF];
	logic        sq_bad_sk [LNF];
	logic [31:0] sq_mn_sk  [LNF];
	logic [31:0] sq_md_sk  [LNF];
	logic [28:0] sq_yn_sk  [LNF];
	logic [28:0] sq_yd_sk  [LNF];

	for (genvar k = 0; k < LNF; k++) begin : g_sq
		logic        v_i, bad_i;
		logic [31:0] mn_i, md_i;
		logic [28:0] yn_i, yd_i, yn_o, yd_o;
		logic [32:0] rn, rd;

		if (k == 0) begin : g_head
			assign v_i   = v_s1;
			assign bad_i = bad_s1;
			assign mn_i  = mn_s1;
			assign md_i  = md_s1;
			assign yn_i  = {xn_s1, 24'd0};
			assign yd_i  = {xd_s1, 24'd0};
		end else begin : g_tail
			assign v_i   = sq_v_sk[k-1];
			assign bad_i = sq_bad_sk[k-1];
			assign mn_i  = sq_mn_sk[k-1];
			assign md_i  = sq_md_sk[k-1];
			assign yn_i  = sq_yn_sk[k-1];
			assign yd_i  = sq_yd_sk[k-1];
		end

		assign rn = sq_step(mn_i);
		assign rd = sq_step(md_i);

		always_comb begin
			yn_o = yn_i;
			yd_o = yd_i;
			yn_o[LNF-1-k] = rn[32];
			yd_o[LNF-1-k] = rd[32];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_sk[k] <= 1'b0;
			else if (adv) sq_v_sk[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_bad_sk[k] <= bad_i;
				sq_mn_sk[k]  <= rn[31:0];
				sq_md_sk[k]  <= rd[31:0];
				sq_yn_sk[k]  <= yn_o;
				sq_yd_sk[k]  <= yd_o;
			end
		end
	end

	// ---- s26: log2 * ln2, rounded half up to Q24
	logic        v_s26, bad_s26;
	logic [28:0] ln_n_s26, ln_d_s26;
	logic [61:0] pn, pd;

	assign pn = 62'(sq_yn_sk[LNF-1]) * 62'(ntl_pkg::LN2_Q32) + 62'(64'h8000_0000);
	assign pd = 62'(sq_yd_sk[LNF-1]) * 62'(ntl_pkg::LN2_Q32) + 62'(64'h8000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s26 <= 1'b0;
		else if (adv) v_s26 <= sq_v_sk[LNF-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s26  <= sq_bad_sk[LNF-1];
			ln_n_s26 <= pn[60:32];
			ln_d_s26 <= pd[60:32];
		end
	end

	// ---- s27: ln R as sign and magnitude
	logic        v_s27, bad_s27, sl_s27;
	logic [28:0] lm_s27;
	logic signed [29:0] lnd;

	assign lnd = $signed({1'b0, ln_n_s26}) - $signed({1'b0, ln_d_s26});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s27 <= 1'b0;
		else if (adv) v_s27 <= v_s26;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s27 <= bad_s26;
			sl_s27  <= lnd[29];
			lm_s27  <= lnd[29] ? 29'(-lnd) : lnd[28:0];
		end
	end

	// ---- s28: L^2, B*L partial products
	logic        v_s28, bad_s28, sl_s28, sbl_s28;
	logic [28:0] lm_s28;
	logic [33:0] l2_s28;
	logic [52:0] bpl_s28, bph_s28;
	logic [47:0] bm;
	logic [57:0] l2p;

	assign bm  = cfg.coef_b[47] ? 48'(-cfg.coef_b) : 48'(cfg.coef_b);
	assign l2p = lm_s27 * lm_s27;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s28 <= 1'b0;
		else if (adv) v_s28 <= v_s27;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s28 <= bad_s27;
			sl_s28  <= sl_s27;
			sbl_s28 <= cfg.coef_b[47] ^ sl_s27;
			lm_s28  <= lm_s27;
			l2_s28  <= l2p[57:24];
			bpl_s28 <= bm[23:0] * lm_s27;
			bph_s28 <= bm[47:24] * lm_s27;
		end
	end

	// ---- s29: L^3, B*L magnitude (truncated toward zero)
	logic        v_s29, bad_s29, sl_s29, sbl_s29;
	logic [38:0] l3_s29;
	logic [53:0] blm_s29;
	logic [62:0] l3p;

	assign l3p = l2_s28 * lm_s28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s29 <= 1'b0;
		else if (adv) v_s29 <= v_s28;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s29 <= bad_s28;
			sl_s29  <= sl_s28;
			sbl_s29 <= sbl_s28;
			l3_s29  <= l3p[62:24];
			blm_s29 <= 54'(bph_s28) + 54'(bpl_s28[52:24]);
		end
	end

	// ---- s30: C*L^3 partial products, A + B*L
	logic        v_s30, bad_s30, scl_s30;
	logic [62:0] cpl_s30, cph_s30;
	logic signed [63:0] part_s30;
	logic [47:0] cm;
	logic signed [63:0] a64, bl64;

	assign cm   = cfg.coef_c[47] ? 48'(-cfg.coef_c) : 48'(cfg.coef_c);
	assign a64  = 64'(cfg.coef_a);
	assign bl64 = $signed({10'd0, blm_s29});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s30 <= 1'b0;
		else if (adv) v_s30 <= v_s29;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s30  <= bad_s29;
			scl_s30  <= cfg.coef_c[47] ^ sl_s29;
			cpl_s30  <= cm[23:0] * l3_s29;
			cph_s30  <= cm[47:24] * l3_s29;
			part_s30 <= a64 + (sbl_s29 ? -bl64 : bl64);
		end
	end

	// ---- s31: C*L^3 magnitude
	logic        v_s31, bad_s31, scl_s31;
	logic [63:0] clm_s31;
	logic signed [63:0] part_s31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s31 <= 1'b0;
		else if (adv) v_s31 <= v_s30;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s31  <= bad_s30;
			scl_s31  <= scl_s30;
			part_s31 <= part_s30;
			clm_s31  <= 64'(cph_s30) + 64'(cpl_s30[62:24]);
		end
	end

	// ---- s32: reciprocal temperature sum
	logic        v_s32, bad_s32;
	logic signed [63:0] inv_s32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s32 <= 1'b0;
		else if (adv) v_s32 <= v_s31;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s32 <= bad_s31;
			inv_s32 <= part_s31 + (scl_s31 ? -$signed(clm_s31) : $signed(clm_s31));
		end
	end

	// ---- s33: divisor magnitude
	logic        v_s33, bad_s33, neg_s33, zero_s33;
	logic [63:0] ui_s33;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s33 <= 1'b0;
		else if (adv) v_s33 <= v_s32;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s33  <= bad_s32;
			neg_s33  <= inv_s32[63];
			zero_s33 <= (inv_s32 == '0);
			ui_s33   <= inv_s32[63] ? 64'(-inv_s32) : 64'(inv_s32);
		end
	end

	// ---- s34: rounded dividend; quotient of 2^41 or more flagged at once
	logic        v_s34, bad_s34, neg_s34, lim_s34;
	logic [63:0] ui_s34, r_s34;
	logic [QB-1:0] dlo_s34;
	logic [63:0] dvd;

	assign dvd = KEL_NUM + (ui_s33 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s34 <= 1'b0;
		else if (adv) v_s34 <= v_s33;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s34 <= bad_s33;
			neg_s34 <= neg_s33;
			lim_s34 <= zero_s33 || (64'(dvd[63:QB]) >= ui_s33);
			ui_s34  <= ui_s33;
			r_s34   <= 64'(dvd[63:QB]);
			dlo_s34 <= dvd[QB-1:0];
		end
	end

	// ---- restoring division, one quotient bit per stage
	logic          dv_v_sk   [QB];
	logic          dv_bad_sk [QB];
	logic          dv_neg_sk [QB];
	logic          dv_lim_sk [QB];
	logic [63:0]   dv_ui_sk  [QB];
	logic [63:0]   dv_r_sk   [QB];
	logic [QB-1:0] dv_dlo_sk [QB];
	logic [QB-1:0] dv_q_sk   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_dv
		logic          v_i, bad_i, neg_i, lim_i, ge;
		logic [63:0]   ui_i, r_i, rr;
		logic [QB-1:0] dlo_i, q_i, q_o;

		if (k == 0) begin : g_head
			assign v_i   = v_s34;
			assign bad_i = bad_s34;
			assign neg_i = neg_s34;
			assign lim_i = lim_s34;
			assign ui_i  = ui_s34;
			assign r_i   = r_s34;
			assign dlo_i = dlo_s34;
			assign q_i   = '0;
		end else begin : g_tail
			assign v_i   = dv_v_sk[k-1];
			assign bad_i = dv_bad_sk[k-1];
			assign neg_i = dv_neg_sk[k-1];
			assign lim_i = dv_lim_sk[k-1];
			assign ui_i  = dv_ui_sk[k-1];
			assign r_i   = dv_r_sk[k-1];
			assign dlo_i = dv_dlo_sk[k-1];
			assign q_i   = dv_q_sk[k-1];
		end

		assign rr = {r_i[62:0], dlo_i[QB-1-k]};
		assign ge = (rr >= ui_i);

		always_comb begin
			q_o = q_i;
			q_o[QB-1-k] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_sk[k] <= 1'b0;
			else if (adv) dv_v_sk[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_bad_sk[k] <= bad_i;
				dv_neg_sk[k] <= neg_i;
				dv_lim_sk[k] <= lim_i;
				dv_ui_sk[k]  <= ui_i;
				dv_r_sk[k]   <= ge ? rr - ui_i : rr;
				dv_dlo_sk[k] <= dlo_i;
				dv_q_sk[k]   <= q_o;
			end
		end
	end

	// ---- output register: celsius and limit check
	logic [QB-1:0]      qf;
	logic               over;
	logic signed [42:0] qs, tc;
	logic [1:0]         st_d;
	logic signed [15:0] temp_d;
	logic               vld_q;
	logic signed [15:0] temp_q;
	logic [1:0]         st_q;

	assign qf   = dv_q_sk[QB-1];
	assign over = qf[QB-1] && (qf[QB-2:0] != '0);
	assign qs   = $signed({2'b00, qf});
	assign tc   = (dv_neg_sk[QB-1] ? -qs : qs) - $signed({27'd0, ntl_pkg::KELVIN_CENTI});

	always_comb begin
		st_d   = ntl_pkg::ST_OK;
		temp_d = '0;
		if (dv_bad_sk[QB-1]) begin
			st_d = ntl_pkg::ST_RANGE;
		end else if (dv_lim_sk[QB-1] || over || (tc < 43'(cfg.temp_floor))
				|| (tc > 43'(cfg.temp_ceiling))) begin
			st_d = ntl_pkg::ST_LIMIT;
		end else begin
			temp_d = tc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (adv) vld_q <= dv_v_sk[QB-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q <= temp_d;
			st_q   <= st_d;
		end
	end

	assign res_vld    = vld_q;
	assign res_temp   = temp_q;
	assign res_status = st_q;

	`ASSERT_IMPL(a_ok_in_limits, clk, arst_n, vld_q && (st_q == ntl_pkg::ST_OK), (temp_q >= cfg.temp_floor) && (temp_q <= cfg.temp_ceiling))
	`ASSERT_IMPL(a_fail_zero, clk, arst_n, vld_q && (st_q != ntl_pkg::ST_OK), temp_q == '0)

endmodule

[test/tb_ntc_thermistor_linearizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntc_thermistor_linearizer_top
// Drives tap voltages through the linearizer under several register settings,
// predicts each temperature and status in fixed point and checks every result
// beat in order, with random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_ntc_thermistor_linearizer_top;

	localparam int FRAC = 48;
	localparam longint unsigned LN2_FIX = 64'hB17217F8;
	localparam longint CURVE_A = 64'd317780000000;
	localparam longint CURVE_B = 64'd65892000000;
	localparam longint CURVE_C = 64'd24700000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [47:0] cfg_data;

	ntl_in_if  sample_ch();
	ntl_out_if result_ch();

	ntc_thermistor_linearizer_top #(.COEF_FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n), .sample(sample_ch), .result(result_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// local copy of the register file
	longint      sh_a, sh_b, sh_c, lim_floor, lim_ceiling;
	longint unsigned ref_mv, r_fixed;
	bit          on_top;

	logic signed [15:0]           temps_due[$];
	ntl_pkg::ntl_status_t         status_due[$];
	int          mismatches;
	bit          calm;
	bit          hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	function automatic longint unsigned ln_fix(input longint unsigned x);
		int unsigned     e;
		longint unsigned t, m, y;
		e = 0;
		t = x;
		while (t > 1) begin
			t = t >> 1;
			e++;
		end
		m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		y = longint'(e) << 24;
		for (int i = 23; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				y = y | (64'd1 << i);
			end
		end
		return (y * LN2_FIX + 64'h8000_0000) >> 32;
	endfunction

	// product >> 24, truncated toward zero, kept to 62 bits
	function automatic longint mul_fix(input longint a, input longint b);
		logic [127:0]    p;
		longint unsigned r;
		bit              neg;
		neg = (a < 0) != (b < 0);
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		r = 64'(p >> 24) & 64'h3FFF_FFFF_FFFF_FFFF;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic void temp_of_tap(input logic [11:0] tap,
			output logic signed [15:0] tc, output ntl_pkg::ntl_status_t st);
		longint unsigned num, den, ui, q;
		longint          lnr, l3, inv, t;
		tc = '0;
		st = ntl_pkg::ST_RANGE;
		if (tap == 0 || tap >= ref_mv || r_fixed == 0) return;
		if (on_top) begin
			num = r_fixed * (ref_mv - tap);
			den = tap;
		end else begin
			num = r_fixed * tap;
			den = ref_mv - tap;
		end
		lnr = longint'(ln_fix(num)) - longint'(ln_fix(den));
		l3 = mul_fix(mul_fix(lnr, lnr), lnr);
		inv = sh_a + mul_fix(sh_b, lnr) + mul_fix(sh_c, l3);
		st = ntl_pkg::ST_LIMIT;
		if (inv == 0) return;
		ui = inv < 0 ? -inv : inv;
		q = ((64'd100 << FRAC) + ui / 2) / ui;
		if (q > (64'd1 << 40)) return;
		t = (inv < 0 ? -longint'(q) : longint'(q)) - 27315;
		if (t < lim_floor || t > lim_ceiling) return;
		tc = t[15:0];
		st = ntl_pkg::ST_OK;
	endfunction

	task automatic write_reg(input ntl_pkg::ntl_reg_t idx, input longint val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val[47:0];
		case (idx)
			ntl_pkg::REG_COEF_A:       sh_a = {{16{val[47]}}, val[47:0]};
			ntl_pkg::REG_COEF_B:       sh_b = {{16{val[47]}}, val[47:0]};
			ntl_pkg::REG_COEF_C:       sh_c = {{16{val[47]}}, val[47:0]};
			ntl_pkg::REG_REF_MV:       ref_mv = val[11:0];
			ntl_pkg::REG_FIXED_OHMS:   r_fixed = val[19:0];
			ntl_pkg::REG_ON_TOP:       on_top = val[0];
			ntl_pkg::REG_TEMP_FLOOR:   lim_floor = {{48{val[15]}}, val[15:0]};
			ntl_pkg::REG_TEMP_CEILING: lim_ceiling = {{48{val[15]}}, val[15:0]};
			default: ;
		endcase
	endtask

	task automatic setup(input longint a, input longint b, input longint c,
			input int rmv, input int fo, input bit top, input int fl, input int ce);
		write_reg(ntl_pkg::REG_COEF_A, a);
		write_reg(ntl_pkg::REG_COEF_B, b);
		write_reg(ntl_pkg::REG_COEF_C, c);
		write_reg(ntl_pkg::REG_REF_MV, rmv);
		write_reg(ntl_pkg::REG_FIXED_OHMS, fo);
		write_reg(ntl_pkg::REG_ON_TOP, top);
		write_reg(ntl_pkg::REG_TEMP_FLOOR, fl);
		write_reg(ntl_pkg::REG_TEMP_CEILING, ce);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// called at a clock step; leaves valid high after the accepting edge, or, unless calm, at random drops it
	task automatic offer_sample(input logic [11:0] tap);
		logic signed [15:0]   tc;
		ntl_pkg::ntl_status_t st;
		sample_ch.valid          <= 1'b1;
		sample_ch.tap_millivolts <= tap;
		do @(posedge clk); while (!sample_ch.ready);
		temp_of_tap(tap, tc, st);
		temps_due.push_back(tc);
		status_due.push_back(st);
		if (!calm && $urandom_range(99) < 37) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain;
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (temps_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [11:0] pick_tap;
		case ($urandom_range(9))
			0:       return 12'($urandom_range(4095));
			1:       return 12'(ref_mv);
			2:       return '0;
			default: return (ref_mv > 1) ? 12'($urandom_range(1, ref_mv - 1)) : 12'd1;
		endcase
	endfunction

	// output side: random stalls, or one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				result_ch.ready <= calm || ($urandom_range(99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (temps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: temp %0d status %0d",
						result_ch.temp_centi_c, result_ch.status);
			end else begin
				if (result_ch.temp_centi_c !== temps_due[0] ||
						result_ch.status !== status_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected temp %0d status %0d, got %0d %0d",
							temps_due[0], status_due[0],
							result_ch.temp_centi_c, result_ch.status);
				end
				void'(temps_due.pop_front());
				void'(status_due.pop_front());
			end
		end
	end

	task automatic test_defaults;
		// all coefficients zero: every solvable tap has no finite temperature
		offer_sample(12'd0);
		offer_sample(12'd1500);
		offer_sample(12'd2999);
		offer_sample(12'd3000);
		offer_sample(12'd4095);
		drain();
	endtask

	task automatic test_curve;
		setup(CURVE_A, CURVE_B, CURVE_C, 3300, 10000, 1'b1, -4000, 12500);
		offer_sample(12'd1);
		offer_sample(12'd1650);
		offer_sample(12'd3299);
		offer_sample(12'd3300);
		offer_sample(12'd800);
		drain();
		setup(CURVE_A, CURVE_B, CURVE_C, 4095, 1048575, 1'b0, -32768, 32767);
		offer_sample(12'd1);
		offer_sample(12'd2048);
		offer_sample(12'd4094);
		offer_sample(12'd4095);
		drain();
	endtask

	task automatic test_special_cases;
		// zero fixed resistor, unit reference, floor above ceiling
		setup(CURVE_A, CURVE_B, CURVE_C, 3000, 0, 1'b1, -4000, 12500);
		offer_sample(12'd1500);
		drain();
		setup(CURVE_A, CURVE_B, CURVE_C, 1, 1, 1'b1, -4000, 12500);
		offer_sample(12'd0);
		offer_sample(12'd1);
		drain();
		setup(CURVE_A, CURVE_B, CURVE_C, 3000, 10000, 1'b1, 12500, -4000);
		offer_sample(12'd1500);
		drain();
		// negative reciprocal sum, and a tiny one giving a huge kelvin
		setup(-CURVE_A, -CURVE_B, -CURVE_C, 3000, 10000, 1'b1, -32768, 32767);
		offer_sample(12'd1500);
		drain();
		setup(1, 0, 0, 3000, 10000, 1'b0, -32768, 32767);
		offer_sample(12'd1500);
		drain();
	endtask

	task automatic test_coef_extremes;
		setup(64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF, 64'sh7FFF_FFFF_FFFF,
			4095, 1048575, 1'b1, -32768, 32767);
		offer_sample(12'd1);
		offer_sample(12'd4094);
		drain();
		setup(-64'sh8000_0000_0000, -64'sh8000_0000_0000, -64'sh8000_0000_0000,
			4095, 1, 1'b0, -32768, 32767);
		offer_sample(12'd1);
		offer_sample(12'd4094);
		drain();
	endtask

	task automatic test_random_settings;
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 7)
				setup(CURVE_A + $urandom_range(0, 4000000) - 2000000,
					CURVE_B + $urandom_range(0, 4000000) - 2000000,
					CURVE_C + $urandom_range(0, 40000) - 20000,
					$urandom_range(1, 4095), $urandom_range(1, 1048575),
					$urandom_range(1), -$urandom_range(0, 20000), $urandom_range(0, 32767));
			else
				setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					$urandom_range(4095), $urandom_range(1048575), $urandom_range(1),
					$urandom_range(65535), $urandom_range(65535));
			calm = (ph == 3);
			for (int n = 0; n < 110; n++)
				offer_sample(pick_tap());
			calm = 1'b0;
			drain();
		end
	endtask

	task automatic test_backpressure;
		setup(CURVE_A, CURVE_B, CURVE_C, 3300, 10000, 1'b1, -4000, 12500);
		hold_req = 1'b1;
		for (int n = 0; n < 150; n++)
			offer_sample(pick_tap());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.tap_millivolts = '0;
		mismatches = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		sh_a = 0;
		sh_b = 0;
		sh_c = 0;
		ref_mv = 3000;
		r_fixed = 10000;
		on_top = 1'b1;
		lim_floor = -4000;
		lim_ceiling = 12500;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_curve();
		test_special_cases();
		test_coef_extremes();
		test_random_settings();
		test_backpressure();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && temps_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/ntl_pkg.sv
hdl/ntl_if.sv
hdl/ntl_front.sv
hdl/ntl_queue.sv
hdl/ntl_back.sv
hdl/ntc_thermistor_linearizer_top.sv
test/tb_ntc_thermistor_linearizer_top.sv
